// ===== hdl/assert_macros.svh =====
// assertion helpers used by label_vote_counter.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   `ASSERT_SYNC(lbl, clk, rst, !(cond))

`endif

// ===== hdl/lvc_pkg.sv =====
`default_nettype none

package lvc_pkg;

   // defaults for the top level parameters
   localparam int DEFAULT_VERTICES   = 256;
   localparam int DEFAULT_COUNT_BITS = 16;

   // fixed field widths
   localparam int OP_BITS     = 2;
   localparam int VERTEX_BITS = 8;
   localparam int LABEL_BITS  = 8;
   localparam int LABELS      = 256;
   localparam int RSP_COUNT_BITS = 16;
   localparam int VCOUNT_BITS = 9;

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 9'd256;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_VOTE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_CLEAR
   } lvc_state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic clearing;
   } lvc_cmd_type;

   typedef struct packed {
      logic clear_last;
   } lvc_status_type;

endpackage

`default_nettype wire

// ===== hdl/lvc_ram.sv =====
`default_nettype none

module lvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lvc_ctrl.sv =====
`default_nettype none

module lvc_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lvc_pkg::OP_BITS-1:0]   operation,
   input  wire lvc_pkg::lvc_status_type       status,
   output lvc_pkg::lvc_cmd_type               cmd,
   output logic                               busy
);

   lvc_pkg::lvc_state_type state_ff;
   lvc_pkg::lvc_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lvc_pkg::ST_IDLE: begin
            if (start) begin
               case (operation)
                  lvc_pkg::OP_VOTE:  state_in = lvc_pkg::ST_LOOKUP;
                  lvc_pkg::OP_READ:  state_in = lvc_pkg::ST_LOOKUP;
                  lvc_pkg::OP_CLEAR: state_in = lvc_pkg::ST_CLEAR;
                  default:           state_in = lvc_pkg::ST_IDLE;
               endcase
            end
         end
         lvc_pkg::ST_LOOKUP: state_in = lvc_pkg::ST_UPDATE;
         lvc_pkg::ST_UPDATE: state_in = lvc_pkg::ST_IDLE;
         lvc_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = lvc_pkg::ST_IDLE;
            end
         end
         default: state_in = lvc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      busy         = 1'b1;
      case (state_ff)
         lvc_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         lvc_pkg::ST_UPDATE: cmd.update   = 1'b1;
         lvc_pkg::ST_CLEAR:  cmd.clearing = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // reset starts with a clearing sweep of the stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lvc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lvc_datapath.sv =====
`default_nettype none

module lvc_datapath #(
   parameter int VERTICES   = lvc_pkg::DEFAULT_VERTICES,
   parameter int COUNT_BITS = lvc_pkg::DEFAULT_COUNT_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lvc_pkg::lvc_cmd_type                  cmd,
   output lvc_pkg::lvc_status_type                    status,
   input  wire logic [lvc_pkg::OP_BITS-1:0]           req_operation,
   input  wire logic [lvc_pkg::VERTEX_BITS-1:0]       req_vertex,
   input  wire logic [lvc_pkg::LABEL_BITS-1:0]        req_vote_label,
   input  wire logic [lvc_pkg::VCOUNT_BITS-1:0]       vertex_count,
   output logic                                       rsp_valid,
   output logic      [lvc_pkg::LABEL_BITS-1:0]        rsp_best_label,
   output logic      [lvc_pkg::RSP_COUNT_BITS-1:0]    rsp_best_count,
   output logic                                       rsp_voted
);

   // only 256 vertices can be named by the vertex field
   localparam int VERT_DEPTH = (VERTICES < lvc_pkg::LABELS) ? VERTICES : lvc_pkg::LABELS;
   localparam int VAW        = $clog2(VERT_DEPTH);
   localparam int PAIR_DEPTH = VERT_DEPTH * lvc_pkg::LABELS;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
   localparam int LEAD_W     = lvc_pkg::LABEL_BITS + COUNT_BITS;

   // latched item
   logic [lvc_pkg::OP_BITS-1:0]     op_ff;
   logic [lvc_pkg::VERTEX_BITS-1:0] vtx_ff;
   logic [lvc_pkg::LABEL_BITS-1:0]  lab_ff;

   // clear sweep
   logic [PAIR_AW-1:0] clr_ff;
   logic [PAIR_AW-1:0] clr_in;

   // memories
   logic                   pair_we;
   logic [PAIR_AW-1:0]     pair_waddr;
   logic [COUNT_BITS-1:0]  pair_wdata;
   logic [PAIR_AW-1:0]     pair_raddr;
   logic [COUNT_BITS-1:0]  pair_q;
   logic                   lead_we;
   logic [VAW-1:0]         lead_waddr;
   logic [LEAD_W-1:0]      lead_wdata;
   logic [VAW-1:0]         lead_raddr;
   logic [LEAD_W-1:0]      lead_q;

   logic [lvc_pkg::LABEL_BITS-1:0] lead_lab;
   logic [COUNT_BITS-1:0]          lead_cnt;
   logic [31:0]                    lead_cnt_wide;
   logic [COUNT_BITS-1:0]          pair_inc;
   logic                           in_use;
   logic                           do_vote;
   logic                           take_lead;
   logic                           voted;

   // result registers
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [lvc_pkg::LABEL_BITS-1:0]       rsp_label_ff;
   logic [lvc_pkg::LABEL_BITS-1:0]       rsp_label_in;
   logic [lvc_pkg::RSP_COUNT_BITS-1:0]   rsp_count_ff;
   logic [lvc_pkg::RSP_COUNT_BITS-1:0]   rsp_count_in;
   logic                                 rsp_voted_ff;
   logic                                 rsp_voted_in;

   assign pair_raddr = {vtx_ff[VAW-1:0], lab_ff};
   assign lead_raddr = vtx_ff[VAW-1:0];
   assign lead_lab   = lead_q[LEAD_W-1:COUNT_BITS];
   assign lead_cnt   = lead_q[COUNT_BITS-1:0];
   assign lead_cnt_wide = 32'(lead_cnt);
   assign pair_inc   = pair_q + COUNT_BITS'(1);

   assign in_use = ({1'b0, vtx_ff} < vertex_count)
                && ({1'b0, vtx_ff} < lvc_pkg::VCOUNT_BITS'(VERT_DEPTH));

   assign do_vote   = cmd.update && (op_ff == lvc_pkg::OP_VOTE) && in_use && (pair_q != '1);
   assign take_lead = do_vote && (lead_cnt < pair_inc);
   assign voted     = in_use && (lead_cnt != '0);

   assign status.clear_last = (clr_ff == PAIR_AW'(PAIR_DEPTH - 1));

   always_comb begin
      if (cmd.clearing) begin
         pair_we    = 1'b1;
         pair_waddr = clr_ff;
         pair_wdata = '0;
         lead_we    = (clr_ff[lvc_pkg::LABEL_BITS-1:0] == '0);
         lead_waddr = clr_ff[PAIR_AW-1:lvc_pkg::LABEL_BITS];
         lead_wdata = '0;
      end else begin
         pair_we    = do_vote;
         pair_waddr = pair_raddr;
         pair_wdata = pair_inc;
         lead_we    = take_lead;
         lead_waddr = lead_raddr;
         lead_wdata = {lab_ff, pair_inc};
      end
   end

   always_comb begin
      if (cmd.accept) begin
         clr_in = '0;
      end else if (cmd.clearing && !status.clear_last) begin
         clr_in = clr_ff + PAIR_AW'(1);
      end else begin
         clr_in = '0;
      end
   end

   assign rsp_valid_in = cmd.update && (op_ff == lvc_pkg::OP_READ);
   assign rsp_voted_in = voted;
   assign rsp_label_in = voted ? lead_lab : '0;
   assign rsp_count_in = voted ? lead_cnt_wide[lvc_pkg::RSP_COUNT_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_operation;
         vtx_ff <= req_vertex;
         lab_ff <= req_vote_label;
      end
      rsp_label_ff <= rsp_label_in;
      rsp_count_ff <= rsp_count_in;
      rsp_voted_ff <= rsp_voted_in;
   end

   lvc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_we),
      .wr_addr (pair_waddr),
      .wr_data (pair_wdata),
      .rd_addr (pair_raddr),
      .rd_data (pair_q)
   );

   lvc_ram #(
      .WIDTH (LEAD_W),
      .DEPTH (VERT_DEPTH)
   ) u_lead_ram (
      .clock   (clock),
      .wr_en   (lead_we),
      .wr_addr (lead_waddr),
      .wr_data (lead_wdata),
      .rd_addr (lead_raddr),
      .rd_data (lead_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_label = rsp_label_ff;
   assign rsp_best_count = rsp_count_ff;
   assign rsp_voted      = rsp_voted_ff;

endmodule

`default_nettype wire

// ===== hdl/label_vote_counter.sv =====
// label propagation vote engine. a word is taken when start is high and busy is low;
// a vote adds one to the (vertex, label) count and moves the vertex leader on a strictly
// greater count, a read returns leader label, count and voted flag, a clear zeroes all
// stores. vote and read pass through accept, lookup and update, the lookup set by the
// registered read of the count memories, so busy is high through lookup and update.
// a clear, and the sweep that runs after reset, writes one pair count a cycle and keeps
// busy high until all min(VERTICES,256)*256 pair counts (65536 at the defaults) are zero.
// a read result is on the rsp_ ports for exactly one cycle with rsp_valid high, in the
// cycle after update; the receiver cannot stall, so it must sample it then. the user
// must write vertex_count only while the block is idle; the block does not enforce it.
`default_nettype none

`include "assert_macros.svh"

module label_vote_counter #(
   parameter int VERTICES   = lvc_pkg::DEFAULT_VERTICES,
   parameter int COUNT_BITS = lvc_pkg::DEFAULT_COUNT_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // command word
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [lvc_pkg::OP_BITS-1:0]           req_operation,
   input  wire logic [lvc_pkg::VERTEX_BITS-1:0]       req_vertex,
   input  wire logic [lvc_pkg::LABEL_BITS-1:0]        req_vote_label,
   // result word
   output logic                                       rsp_valid,
   output logic      [lvc_pkg::LABEL_BITS-1:0]        rsp_best_label,
   output logic      [lvc_pkg::RSP_COUNT_BITS-1:0]    rsp_best_count,
   output logic                                       rsp_voted,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [lvc_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [lvc_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [lvc_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready
);

   lvc_pkg::lvc_cmd_type    cmd;
   lvc_pkg::lvc_status_type status;

   // vertex_count register, word 0
   logic [lvc_pkg::VCOUNT_BITS-1:0] vcount_ff;
   logic [lvc_pkg::VCOUNT_BITS-1:0] vcount_in;
   logic                            csr_wr;
   logic                            csr_hit;

   // terms watched by the assertions
   logic                            clear_taken;
   logic                            unvoted_nonzero;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == lvc_pkg::REG_VERTEX_COUNT);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   // write lands on the access phase edge
   always_comb begin
      vcount_in = vcount_ff;
      if (csr_wr) begin
         vcount_in = pwdata[lvc_pkg::VCOUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= lvc_pkg::VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // reads outside the register come back zero
   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = lvc_pkg::CSR_DATA_BITS'(vcount_ff);
      end
   end

   // sequencer: idle, lookup, update, clear sweep
   lvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // item registers, count memories and result registers
   lvc_datapath #(
      .VERTICES   (VERTICES),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_vertex     (req_vertex),
      .req_vote_label (req_vote_label),
      .vertex_count   (vcount_ff),
      .rsp_valid      (rsp_valid),
      .rsp_best_label (rsp_best_label),
      .rsp_best_count (rsp_best_count),
      .rsp_voted      (rsp_voted)
   );

   assign clear_taken     = start && !busy && (req_operation == lvc_pkg::OP_CLEAR);
   assign unvoted_nonzero = rsp_valid && !rsp_voted
                         && (rsp_best_count != '0 || rsp_best_label != '0);

   // a result strobe lasts exactly one cycle
   `ASSERT_SYNC(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)

   // a result only follows a busy update cycle
   `ASSERT_SYNC(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy))

   // an accepted clear starts the sweep at once
   `ASSERT_SYNC(a_clear_busy, clock, reset, clear_taken |=> busy)

   // a vertex without votes reports zero label and count
   `ASSERT_NEVER(a_unvoted_zero, clock, reset, unvoted_nonzero)

endmodule

`default_nettype wire

// ===== test/label_vote_counter_test.sv =====
`timescale 1ns / 1ps

module label_vote_counter_test;
   import lvc_pkg::*;

   localparam int NODES = DEFAULT_VERTICES;
   localparam int COUNT_MAX = (1 << DEFAULT_COUNT_BITS) - 1;
   // a clear sweeps every pair count, so the stall limit sits well above that
   localparam int STALL_LIMIT = 200000;
   localparam int PRINT_LIMIT = 20;
   // operation code the block has no use for
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [LABEL_BITS-1:0]     best_label;
      logic [RSP_COUNT_BITS-1:0] best_count;
      logic                      voted;
   } read_result_t;

   typedef enum {ROW_WORD, ROW_VCOUNT} row_kind_e;

   typedef struct {
      row_kind_e              kind;
      logic [OP_BITS-1:0]     op;
      logic [VERTEX_BITS-1:0] vertex;
      logic [LABEL_BITS-1:0]  label;
      int                     reps;
      int                     setting;
      bit                     typed;
      read_result_t           want;
   } plan_row_t;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_BITS-1:0]       req_operation = '0;
   logic [VERTEX_BITS-1:0]   req_vertex = '0;
   logic [LABEL_BITS-1:0]    req_vote_label = '0;
   logic                     rsp_valid;
   logic [LABEL_BITS-1:0]    rsp_best_label;
   logic [RSP_COUNT_BITS-1:0] rsp_best_count;
   logic                     rsp_voted;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   label_vote_counter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_vertex     (req_vertex),
      .req_vote_label (req_vote_label),
      .rsp_valid      (rsp_valid),
      .rsp_best_label (rsp_best_label),
      .rsp_best_count (rsp_best_count),
      .rsp_voted      (rsp_voted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // shadow of the vote stores and the vertex_count register
   bit [RSP_COUNT_BITS-1:0] pair_tally [NODES*LABELS];
   bit [LABEL_BITS-1:0]     lead_label [NODES];
   bit [RSP_COUNT_BITS-1:0] lead_count [NODES];
   bit [VCOUNT_BITS-1:0]    vcount_model = VCOUNT_RESET;

   // leader words owed by reads that were taken, oldest first
   read_result_t pending_reads [$];

   // directed plan, walked in order
   plan_row_t plan [$];

   int mismatches = 0;
   int n_checked = 0;
   int n_votes = 0;
   int n_reads = 0;
   int n_clears = 0;
   int n_ignored = 0;
   int n_settings = 0;
   int stalled = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one line per mismatch, quiet after the first few but still counted
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // appends one row to the directed plan
   function automatic void add_row(input plan_row_t row);
      plan.insert(plan.size(), row);
   endfunction

   // applies one word to the shadow stores; a read yields the leader word
   task automatic tally_word(input logic [OP_BITS-1:0] op,
                             input logic [VERTEX_BITS-1:0] v,
                             input logic [LABEL_BITS-1:0] lab,
                             output bit has_rsp, output read_result_t r);
      int slot;
      bit in_use;
      has_rsp = 1'b0;
      r = '0;
      // vertices at or past vertex_count, or past the store, are not in use
      in_use = int'(v) < int'(vcount_model) && int'(v) < NODES;
      case (op)
         OP_VOTE: begin
            if (in_use) begin
               slot = int'(v) * LABELS + int'(lab);
               // a saturated pair count swallows the vote
               if (int'(pair_tally[slot]) < COUNT_MAX) begin
                  pair_tally[slot]++;
                  // strictly greater only, so the earlier label keeps a tie
                  if (lead_count[v] < pair_tally[slot]) begin
                     lead_count[v] = pair_tally[slot];
                     lead_label[v] = lab;
                  end
               end
            end
         end
         OP_READ: begin
            has_rsp = 1'b1;
            if (in_use && lead_count[v] != 0)
               r = '{best_label: lead_label[v], best_count: lead_count[v], voted: 1'b1};
         end
         OP_CLEAR: begin
            foreach (pair_tally[i]) pair_tally[i] = '0;
            foreach (lead_label[i]) lead_label[i] = '0;
            foreach (lead_count[i]) lead_count[i] = '0;
         end
         default: ;
      endcase
   endtask

   // holds the word on the req_ ports until the block takes it
   task automatic send_word(input logic [OP_BITS-1:0] op,
                            input logic [VERTEX_BITS-1:0] v,
                            input logic [LABEL_BITS-1:0] lab,
                            input bit typed, input read_result_t want);
      bit has_rsp;
      read_result_t r;
      start <= 1'b1;
      req_operation <= op;
      req_vertex <= v;
      req_vote_label <= lab;
      do @(posedge clock); while (busy !== 1'b0);
      tally_word(op, v, lab, has_rsp, r);
      // typed rows carry their own expectation, the rest use the shadow
      if (has_rsp) pending_reads.insert(pending_reads.size(), typed ? want : r);
      case (op)
         OP_VOTE:  n_votes++;
         OP_READ:  n_reads++;
         OP_CLEAR: n_clears++;
         default:  n_ignored++;
      endcase
   endtask

   // stop sending, let owed reads land, let the last vote and any clear finish
   task automatic settle();
      start <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // two-phase write of vertex_count, then read it back
   task automatic set_vertex_count(input int setting);
      logic [CSR_DATA_BITS-1:0] data;
      data = CSR_DATA_BITS'(setting & ((1 << VCOUNT_BITS) - 1));
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(4 * REG_VERTEX_COUNT);
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      vcount_model = data[VCOUNT_BITS-1:0];
      n_settings++;
      // straight into the read setup, psel stays high
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== data) report_mismatch("vertex_count readback", prdata, data);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic plan_row_t word_row(input logic [OP_BITS-1:0] op,
                                          input logic [VERTEX_BITS-1:0] v,
                                          input logic [LABEL_BITS-1:0] lab,
                                          input int reps = 1);
      plan_row_t row;
      row = '{kind: ROW_WORD, op: op, vertex: v, label: lab, reps: reps,
              setting: 0, typed: 1'b0, want: '0};
      return row;
   endfunction

   // read with the leader word written out by hand
   function automatic plan_row_t read_row(input logic [VERTEX_BITS-1:0] v,
                                          input logic [LABEL_BITS-1:0] lab,
                                          input logic [RSP_COUNT_BITS-1:0] cnt,
                                          input logic voted);
      plan_row_t row;
      row = word_row(OP_READ, v, 8'd0);
      row.typed = 1'b1;
      row.want = '{best_label: lab, best_count: cnt, voted: voted};
      return row;
   endfunction

   function automatic plan_row_t count_row(input int setting);
      plan_row_t row;
      row = word_row(OP_UNUSED, 8'd0, 8'd0);
      row.kind = ROW_VCOUNT;
      row.setting = setting;
      return row;
   endfunction

   // result checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin
      read_result_t want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("result word with none owed", rsp_best_label, 0);
         end else begin
            want = pending_reads.pop_front();
            n_checked++;
            if (rsp_best_label !== want.best_label)
               report_mismatch("best_label", rsp_best_label, want.best_label);
            if (rsp_best_count !== want.best_count)
               report_mismatch("best_count", rsp_best_count, want.best_count);
            if (rsp_voted !== want.voted)
               report_mismatch("voted", rsp_voted, want.voted);
         end
      end
   end

   // watchdog: counts cycles in which no word moves either way
   always @(posedge clock) begin
      if (reset === 1'b1 || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stalled <= 0;
      else
         stalled <= stalled + 1;
      if (stalled >= STALL_LIMIT) begin
         $display("stalled for %0d cycles, %0d reads still owed", stalled,
                  pending_reads.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [VERTEX_BITS-1:0] hot_v [4];
      logic [LABEL_BITS-1:0]  hot_l [4];
      int settings [6];
      int span;
      int roll;
      bit quiet;

      // reset, then wait out the clearing sweep that follows it
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      // directed plan: fresh stores, field extremes, ties, range limits, repeats
      add_row(read_row(8'd0, 8'd0, 16'd0, 1'b0));
      add_row(read_row(8'd255, 8'd0, 16'd0, 1'b0));
      add_row(word_row(OP_VOTE, 8'd0, 8'd0));
      add_row(read_row(8'd0, 8'd0, 16'd1, 1'b1));
      add_row(word_row(OP_VOTE, 8'd255, 8'd255));
      add_row(read_row(8'd255, 8'd255, 16'd1, 1'b1));
      // tie at one vote: the first label stays leader
      add_row(word_row(OP_VOTE, 8'd255, 8'd7));
      add_row(read_row(8'd255, 8'd255, 16'd1, 1'b1));
      add_row(word_row(OP_VOTE, 8'd255, 8'd7));
      add_row(read_row(8'd255, 8'd7, 16'd2, 1'b1));
      // unused operation code, no result and no store change
      add_row(word_row(OP_UNUSED, 8'd1, 8'd1));
      // single vertex in use: vertex 1 is out of range
      add_row(count_row(1));
      add_row(word_row(OP_VOTE, 8'd1, 8'd3));
      add_row(read_row(8'd1, 8'd0, 16'd0, 1'b0));
      add_row(read_row(8'd0, 8'd0, 16'd1, 1'b1));
      // no vertex in use at all
      add_row(count_row(0));
      add_row(word_row(OP_VOTE, 8'd0, 8'd9));
      add_row(read_row(8'd0, 8'd0, 16'd0, 1'b0));
      // count past the store size acts as the full store
      add_row(count_row(300));
      add_row(read_row(8'd255, 8'd7, 16'd2, 1'b1));
      add_row(count_row(NODES));
      // repeated votes on one pair, checked against the shadow
      add_row(word_row(OP_VOTE, 8'd5, 8'd200, 3));
      add_row(word_row(OP_READ, 8'd5, 8'd0));
      add_row(word_row(OP_CLEAR, 8'd0, 8'd0));
      add_row(read_row(8'd5, 8'd0, 16'd0, 1'b0));
      add_row(read_row(8'd255, 8'd0, 16'd0, 1'b0));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_VCOUNT) begin
            settle();
            set_vertex_count(plan[i].setting);
         end else begin
            repeat (plan[i].reps)
               send_word(plan[i].op, plan[i].vertex, plan[i].label, plan[i].typed,
                         plan[i].want);
         end
      end

      // random phases: full store, single vertex, random, oversize, few vertices, full store
      settings[0] = NODES;
      settings[1] = 1;
      settings[2] = $urandom_range(2, NODES - 1);
      settings[3] = (1 << VCOUNT_BITS) - 1;
      settings[4] = $urandom_range(2, 16);
      settings[5] = NODES;

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         set_vertex_count(settings[ph]);
         // a clear is a whole sweep, so only every other phase opens with one
         if (ph % 2 == 0)
            send_word(OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
         // a few hot vertices and labels so counts pile up, tie and overtake
         span = (int'(vcount_model) > NODES) ? NODES : int'(vcount_model);
         for (int h = 0; h < 4; h++) begin
            hot_v[h] = (span > 0) ? 8'($urandom_range(0, span - 1)) : 8'($urandom);
            hot_l[h] = 8'($urandom);
         end
         // one phase runs back to back with no sender gaps
         quiet = (ph == 1);
         for (int k = 0; k < 315; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
               send_word(OP_VOTE, hot_v[$urandom_range(0, 3)], hot_l[$urandom_range(0, 3)],
                         1'b0, '0);
            else if (roll < 85)
               send_word(OP_READ, hot_v[$urandom_range(0, 3)], 8'($urandom), 1'b0, '0);
            else if (roll < 92)
               send_word(OP_VOTE, 8'($urandom), 8'($urandom), 1'b0, '0);
            else if (roll < 97)
               send_word(OP_READ, 8'($urandom), 8'($urandom), 1'b0, '0);
            else
               send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 1'b0, '0);
            // hold off mid phase until every owed read is back
            if (ph == 2 && k == 150) settle();
            if (!quiet && $urandom_range(0, 99) < 10) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end

      // drain, then a few cycles to catch any stray strobe
      start <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d votes, %0d reads, %0d clears, %0d unused-op words", n_votes,
               n_reads, n_clears, n_ignored);
      $display("%0d vertex_count settings, %0d leader words checked, %0d mismatches",
               n_settings, n_checked, mismatches);
      if (mismatches == 0 && pending_reads.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== label_vote_counter.f =====
+incdir+hdl
hdl/lvc_pkg.sv
hdl/lvc_ram.sv
hdl/lvc_ctrl.sv
hdl/lvc_datapath.sv
hdl/label_vote_counter.sv
test/label_vote_counter_test.sv
